// File: rtl/core/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared constants and the record type of the receiver line packer.
// ----------------------------------------------------------------------------
package rcp_pkg;

    localparam int REC_BYTES = 11;
    localparam int IDX_W     = $clog2(REC_BYTES);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REC_BYTES - 1);

    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_C     = 8'h63;
    localparam logic [7:0] CHAR_K     = 8'h6B;

    localparam int MIN_LINE = 30;

    localparam logic [39:0] PREFIX_SENSOR = 40'h5442522053;
    localparam logic [31:0] CODE_S256     = 32'h53323536;
    localparam logic [31:0] CODE_R64K     = 32'h5236344B;
    localparam logic [31:0] CODE_R04K     = 32'h5230344B;
    localparam logic [31:0] CODE_R256     = 32'h52323536;
    localparam logic [7:0]  CODE_NONE     = 8'hFF;

    localparam logic [1:0] ACK_IDLE = 2'd0;
    localparam logic [1:0] ACK_GOTA = 2'd1;
    localparam logic [1:0] ACK_GOTC = 2'd2;

    typedef struct packed {
        logic [REC_BYTES-1:0][7:0] bytes;
        logic                      sensor;
        logic [31:0]               det_total;
        logic [31:0]               sen_total;
    } record_t;

endpackage

// File: rtl/core/receiver_csv_record_packer.sv
// ----------------------------------------------------------------------------
// receiver_csv_record_packer
// Parses comma-separated receiver lines and emits 11-byte packed records.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, but a newline waits as below; a record
// drains one word per cycle while rec_ready is high. Its first word is valid
// the cycle after its newline. Any newline waits while a record is draining;
// it passes at the edge that takes the last word. Reset clears parser state,
// counts and the buffer's valid flag at once; the buffer data has no reset.
module receiver_csv_record_packer #(
    parameter int LINE_CHARS = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  logic        ch_valid,
    output logic        ch_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        is_sensor_record,
    output logic [31:0] detections_total,
    output logic [31:0] sensor_total,
    output logic        rec_valid,
    input  logic        rec_ready
);

    rcp_pkg::record_t rec;
    logic             rec_load;
    logic             ser_free;

    rcp_parser #(
        .LINE_CHARS (LINE_CHARS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .ch       (ch),
        .ch_valid (ch_valid),
        .ch_ready (ch_ready),
        .ser_free (ser_free),
        .rec_load (rec_load),
        .rec      (rec)
    );

    rcp_serializer u_serializer (
        .clk              (clk),
        .rst_n            (rst_n),
        .rec_load         (rec_load),
        .rec              (rec),
        .ser_free         (ser_free),
        .rec_valid        (rec_valid),
        .rec_ready        (rec_ready),
        .out_byte         (out_byte),
        .last_byte        (last_byte),
        .is_sensor_record (is_sensor_record),
        .detections_total (detections_total),
        .sensor_total     (sensor_total)
    );

endmodule

// File: rtl/core/rcp_parser.sv
// ----------------------------------------------------------------------------
// rcp_parser
// Per-character field parser; builds the packed record at the newline.
// ----------------------------------------------------------------------------
module rcp_parser #(
    parameter int LINE_CHARS = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       ch,
    input  logic             ch_valid,
    output logic             ch_ready,
    input  logic             ser_free,
    output logic             rec_load,
    output rcp_pkg::record_t rec
);

    localparam int LW = $clog2(LINE_CHARS + 1);

    logic [2:0]    field_idx_reg, field_idx_next;
    logic          in_token_reg, in_token_next;
    logic [31:0]   acc_reg, acc_next;
    logic [39:0]   prefix_reg, prefix_next;
    logic [2:0]    plen_reg, plen_next;
    logic          live_reg, live_next;
    logic          sensor_reg, sensor_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic [15:0]   millis_reg, millis_next;
    logic [15:0]   kind_reg, kind_next;
    logic [15:0]   ident_reg, ident_next;
    logic [15:0]   payload_reg, payload_next;
    logic [7:0]    snr_reg, snr_next;
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]    ack_match_reg, ack_match_next;
    logic          ack_seen_reg, ack_seen_next;
    logic [31:0]   det_reg, det_next;
    logic [31:0]   sen_reg, sen_next;

    logic [2:0]  fin_field;
    logic        fin_sensor;
    logic [31:0] fin_stamp;
    logic [15:0] fin_millis, fin_kind, fin_ident, fin_payload;
    logic [7:0]  fin_snr;
    logic [7:0]  code;
    logic [31:0] first4;

    logic        is_nl, take, accept, record_ok, is_digit;
    logic [31:0] acc_e;
    logic [39:0] prefix_e;
    logic [2:0]  plen_e;
    logic        live_e;
    logic [35:0] prod;

    assign is_nl    = (ch == rcp_pkg::CHAR_NL);
    assign ch_ready = ser_free || !is_nl;
    assign accept   = ch_valid && ch_ready;
    assign take     = !is_nl && (len_reg < LW'(LINE_CHARS));
    assign is_digit = (ch >= rcp_pkg::CHAR_ZERO) && (ch <= rcp_pkg::CHAR_NINE);
    assign record_ok = !ack_seen_reg && (len_reg > LW'(rcp_pkg::MIN_LINE));

    always_comb
    begin
        first4 = (plen_reg == 3'd5) ? prefix_reg[39:8] : prefix_reg[31:0];
        if (plen_reg < 3'd4)
        begin
            code = rcp_pkg::CODE_NONE;
        end
        else if (first4 == rcp_pkg::CODE_S256)
        begin
            code = 8'd0;
        end
        else if (first4 == rcp_pkg::CODE_R64K)
        begin
            code = 8'd1;
        end
        else if (first4 == rcp_pkg::CODE_R04K)
        begin
            code = 8'd2;
        end
        else if (first4 == rcp_pkg::CODE_R256)
        begin
            code = 8'd3;
        end
        else
        begin
            code = rcp_pkg::CODE_NONE;
        end
    end

    // close the current token into its field
    always_comb
    begin
        fin_field   = field_idx_reg;
        fin_sensor  = sensor_reg;
        fin_stamp   = stamp_reg;
        fin_millis  = millis_reg;
        fin_kind    = kind_reg;
        fin_ident   = ident_reg;
        fin_payload = payload_reg;
        fin_snr     = snr_reg;
        if (in_token_reg)
        begin
            case (field_idx_reg)
                3'd1: fin_stamp = acc_reg;
                3'd2:
                begin
                    if (plen_reg == 3'd5 && prefix_reg == rcp_pkg::PREFIX_SENSOR)
                    begin
                        fin_sensor = 1'b1;
                    end
                    else
                    begin
                        fin_millis = acc_reg[15:0];
                    end
                end
                3'd3: fin_kind = sensor_reg ? acc_reg[15:0] : {8'h00, code};
                3'd4: fin_ident = sensor_reg ? {8'h00, acc_reg[7:0]} : acc_reg[15:0];
                3'd5: fin_payload = sensor_reg ? {8'h00, acc_reg[7:0]} : acc_reg[15:0];
                3'd6: fin_snr = acc_reg[7:0];
                default: ;
            endcase
            if (field_idx_reg != 3'd7)
            begin
                fin_field = field_idx_reg + 3'd1;
            end
        end
    end

    assign acc_e    = in_token_reg ? acc_reg : 32'd0;
    assign prefix_e = in_token_reg ? prefix_reg : 40'd0;
    assign plen_e   = in_token_reg ? plen_reg : 3'd0;
    assign live_e   = in_token_reg ? live_reg : 1'b1;
    assign prod     = ({4'd0, acc_e} << 3) + ({4'd0, acc_e} << 1) + {32'd0, ch[3:0]};

    always_comb
    begin
        rec.sensor = fin_sensor;
        rec.det_total = det_reg + {31'd0, !fin_sensor};
        rec.sen_total = sen_reg + {31'd0, fin_sensor};
        rec.bytes[0] = fin_stamp[31:24];
        rec.bytes[1] = fin_stamp[23:16];
        rec.bytes[2] = fin_stamp[15:8];
        rec.bytes[3] = fin_stamp[7:0];
        if (!fin_sensor)
        begin
            rec.bytes[4]  = fin_kind[7:0];
            rec.bytes[5]  = fin_ident[15:8];
            rec.bytes[6]  = fin_ident[7:0];
            rec.bytes[7]  = fin_payload[15:8];
            rec.bytes[8]  = fin_payload[7:0];
            rec.bytes[9]  = {fin_snr[5:0], 2'b00} | fin_millis[15:8];
            rec.bytes[10] = fin_millis[7:0];
        end
        else
        begin
            rec.bytes[4]  = 8'hFF;
            rec.bytes[5]  = fin_kind[15:8];
            rec.bytes[6]  = fin_kind[7:0];
            rec.bytes[7]  = fin_ident[7:0];
            rec.bytes[8]  = fin_payload[7:0];
            rec.bytes[9]  = 8'hFF;
            rec.bytes[10] = fin_snr;
        end
    end

    always_comb
    begin
        field_idx_next = field_idx_reg;
        in_token_next  = in_token_reg;
        acc_next       = acc_reg;
        prefix_next    = prefix_reg;
        plen_next      = plen_reg;
        live_next      = live_reg;
        sensor_next    = sensor_reg;
        stamp_next     = stamp_reg;
        millis_next    = millis_reg;
        kind_next      = kind_reg;
        ident_next     = ident_reg;
        payload_next   = payload_reg;
        snr_next       = snr_reg;
        len_next       = len_reg;
        ack_match_next = ack_match_reg;
        ack_seen_next  = ack_seen_reg;
        det_next       = det_reg;
        sen_next       = sen_reg;
        rec_load       = 1'b0;
        if (accept && is_nl)
        begin
            if (record_ok)
            begin
                rec_load = 1'b1;
                det_next = rec.det_total;
                sen_next = rec.sen_total;
            end
            // clear the line
            field_idx_next = 3'd0;
            in_token_next  = 1'b0;
            acc_next       = 32'd0;
            prefix_next    = 40'd0;
            plen_next      = 3'd0;
            live_next      = 1'b0;
            sensor_next    = 1'b0;
            stamp_next     = 32'd0;
            millis_next    = 16'd0;
            kind_next      = 16'd0;
            ident_next     = 16'd0;
            payload_next   = 16'd0;
            snr_next       = 8'd0;
            len_next       = '0;
            ack_match_next = rcp_pkg::ACK_IDLE;
            ack_seen_next  = 1'b0;
        end
        else if (accept && take)
        begin
            len_next = len_reg + LW'(1);
            if (ch == rcp_pkg::CHAR_A)
            begin
                ack_match_next = rcp_pkg::ACK_GOTA;
            end
            else if (ack_match_reg == rcp_pkg::ACK_GOTA && ch == rcp_pkg::CHAR_C)
            begin
                ack_match_next = rcp_pkg::ACK_GOTC;
            end
            else if (ack_match_reg == rcp_pkg::ACK_GOTC && ch == rcp_pkg::CHAR_K)
            begin
                ack_seen_next  = 1'b1;
                ack_match_next = rcp_pkg::ACK_IDLE;
            end
            else
            begin
                ack_match_next = rcp_pkg::ACK_IDLE;
            end
            if (ch == rcp_pkg::CHAR_COMMA)
            begin
                field_idx_next = fin_field;
                in_token_next  = 1'b0;
                sensor_next    = fin_sensor;
                stamp_next     = fin_stamp;
                millis_next    = fin_millis;
                kind_next      = fin_kind;
                ident_next     = fin_ident;
                payload_next   = fin_payload;
                snr_next       = fin_snr;
            end
            else
            begin
                in_token_next = 1'b1;
                acc_next      = acc_e;
                prefix_next   = prefix_e;
                plen_next     = plen_e;
                live_next     = live_e;
                if (plen_e < 3'd5)
                begin
                    prefix_next = {prefix_e[31:0], ch};
                    plen_next   = plen_e + 3'd1;
                end
                if (live_e)
                begin
                    if (is_digit)
                    begin
                        acc_next = (prod[35:32] != 4'd0) ? 32'hFFFFFFFF : prod[31:0];
                    end
                    else
                    begin
                        live_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_idx_reg <= 3'd0;
            in_token_reg  <= 1'b0;
            acc_reg       <= 32'd0;
            prefix_reg    <= 40'd0;
            plen_reg      <= 3'd0;
            live_reg      <= 1'b0;
            sensor_reg    <= 1'b0;
            stamp_reg     <= 32'd0;
            millis_reg    <= 16'd0;
            kind_reg      <= 16'd0;
            ident_reg     <= 16'd0;
            payload_reg   <= 16'd0;
            snr_reg       <= 8'd0;
            len_reg       <= '0;
            ack_match_reg <= rcp_pkg::ACK_IDLE;
            ack_seen_reg  <= 1'b0;
            det_reg       <= 32'd0;
            sen_reg       <= 32'd0;
        end
        else
        begin
            field_idx_reg <= field_idx_next;
            in_token_reg  <= in_token_next;
            acc_reg       <= acc_next;
            prefix_reg    <= prefix_next;
            plen_reg      <= plen_next;
            live_reg      <= live_next;
            sensor_reg    <= sensor_next;
            stamp_reg     <= stamp_next;
            millis_reg    <= millis_next;
            kind_reg      <= kind_next;
            ident_reg     <= ident_next;
            payload_reg   <= payload_next;
            snr_reg       <= snr_next;
            len_reg       <= len_next;
            ack_match_reg <= ack_match_next;
            ack_seen_reg  <= ack_seen_next;
            det_reg       <= det_next;
            sen_reg       <= sen_next;
        end
    end

endmodule

// File: rtl/core/rcp_serializer.sv
// ----------------------------------------------------------------------------
// rcp_serializer
// Record buffer; sends the packed record one word per handshake.
// ----------------------------------------------------------------------------
module rcp_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rec_load,
    input  rcp_pkg::record_t rec,
    output logic             ser_free,
    output logic             rec_valid,
    input  logic             rec_ready,
    output logic [7:0]       out_byte,
    output logic             last_byte,
    output logic             is_sensor_record,
    output logic [31:0]      detections_total,
    output logic [31:0]      sensor_total
);

    rcp_pkg::record_t              buf_reg;
    logic                          valid_reg;
    logic [rcp_pkg::IDX_W-1:0]     idx_reg;
    logic                          done;

    assign done      = valid_reg && rec_ready && (idx_reg == rcp_pkg::LAST_IDX);
    assign ser_free  = !valid_reg || done;

    assign rec_valid        = valid_reg;
    assign out_byte         = buf_reg.bytes[idx_reg];
    assign last_byte        = (idx_reg == rcp_pkg::LAST_IDX);
    assign is_sensor_record = buf_reg.sensor;
    assign detections_total = buf_reg.det_total;
    assign sensor_total     = buf_reg.sen_total;

    always_ff @(posedge clk)
    begin
        if (rec_load)
        begin
            buf_reg <= rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (rec_load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (valid_reg && rec_ready)
        begin
            idx_reg <= idx_reg + rcp_pkg::IDX_W'(1);
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        rec_load |-> (!valid_reg || done))
        else $error("record loaded over a busy buffer");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= rcp_pkg::LAST_IDX))
        else $error("byte index out of range");

    a_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && rec_ready && !last_byte) |=> (valid_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("record cut short");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        rec_load |=> (valid_reg && idx_reg == '0))
        else $error("record does not start at byte zero");

endmodule

// File: tb/receiver_csv_record_packer_tb.sv
// ----------------------------------------------------------------------------
// receiver_csv_record_packer_tb
// Streams receiver lines into the packer one character per word and checks
// every record word against the table's bytes or a line parser in the bench.
// A short table of lines covers the edge cases, first under one long output
// stall; then random lines follow under three ready/valid idling mixes.
// ----------------------------------------------------------------------------
module receiver_csv_record_packer_tb;

    localparam int         LINE_CHARS     = 50;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DIR_ROWS       = 9;
    localparam logic [7:0] NUL_MARK       = 8'h5E;
    localparam logic [7:0] FILL_BYTE      = 8'hFF;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_REC} row_kind_t;

    typedef struct {
        string       text;
        row_kind_t   kind;
        logic [87:0] bytes;
        logic        sens;
        logic [31:0] det;
        logic [31:0] sen;
    } dir_row_t;

    typedef struct {
        logic [7:0] c;
        int         row;
    } char_item_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        sens;
        logic [31:0] det;
        logic [31:0] sen;
    } rec_word_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{"1,4294967295,65535,S256,65535,65535,63", ROW_REC,
          88'hFF_FF_FF_FF_00_FF_FF_FF_FF_FF_FF, 1'b0, 32'd1, 32'd0},
        '{"1,2,3", ROW_NONE, 88'h0, 1'b0, 32'd0, 32'd0},
        '{"0,0,0,R256,0,0,0,zzzzzzzzzzzzzzzzzzzzzz", ROW_REC,
          88'h00_00_00_00_03_00_00_00_00_00_00, 1'b0, 32'd2, 32'd0},
        '{"5,100,200,R64K,5,6,7,back,zzzzzzzzzzzzzz", ROW_NONE, 88'h0, 1'b0, 32'd0, 32'd0},
        '{"1,2,3,S256,4,5,6,qqqqqqqqqqqqq", ROW_PRED, 88'h0, 1'b0, 32'd0, 32'd0},
        '{"1,2,3,S256,4,5,6,qqqqqqqqqqqqqq", ROW_PRED, 88'h0, 1'b0, 32'd0, 32'd0},
        '{"7,123456,TBR Sensor,65535,300,258,255,xyz", ROW_PRED, 88'h0, 1'b0, 32'd0, 32'd0},
        '{"1,12^34,5^6,R64K,7,8,9,zzzzzzzzzzzzzzz", ROW_PRED, 88'h0, 1'b0, 32'd0, 32'd0},
        '{"", ROW_NONE, 88'h0, 1'b0, 32'd0, 32'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  ch = 8'h00;
    logic        ch_valid = 1'b0;
    logic        ch_ready;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic        is_sensor_record;
    logic [31:0] detections_total;
    logic [31:0] sensor_total;
    logic        rec_valid;
    logic        rec_ready = 1'b0;

    int send_idle_pct = 18;
    int recv_idle_pct = 76;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int cur_row = -1;
    int idle_run = 0;

    int mismatches = 0;
    int chars_taken = 0;
    int words_checked = 0;
    int records_seen = 0;
    int sensor_records = 0;
    int lines_sent = 0;

    char_item_t feed_q [$];
    rec_word_t  rec_exp_q [$];
    rec_word_t  fresh_words [$];
    logic [7:0] line_buf [$];

    // line parser state
    logic [2:0]  fld;
    bit          tok;
    logic [31:0] acc;
    logic [39:0] pfx;
    int          plen;
    bit          live;
    bit          sens;
    logic [31:0] stamp;
    logic [15:0] ms;
    logic [15:0] kt;
    logic [15:0] idn;
    logic [15:0] pay;
    logic [7:0]  snr;
    int          llen;
    logic [1:0]  ackst;
    bit          ackhit;
    logic [31:0] det_cnt = 32'd0;
    logic [31:0] sen_cnt = 32'd0;

    receiver_csv_record_packer #(
        .LINE_CHARS(LINE_CHARS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .ch               (ch),
        .ch_valid         (ch_valid),
        .ch_ready         (ch_ready),
        .out_byte         (out_byte),
        .last_byte        (last_byte),
        .is_sensor_record (is_sensor_record),
        .detections_total (detections_total),
        .sensor_total     (sensor_total),
        .rec_valid        (rec_valid),
        .rec_ready        (rec_ready)
    );

    always #6 clk = ~clk;

    task clear_line_state();
        fld    = 3'd0;
        tok    = 1'b0;
        acc    = 32'd0;
        pfx    = 40'd0;
        plen   = 0;
        live   = 1'b0;
        sens   = 1'b0;
        stamp  = 32'd0;
        ms     = 16'd0;
        kt     = 16'd0;
        idn    = 16'd0;
        pay    = 16'd0;
        snr    = 8'd0;
        llen   = 0;
        ackst  = rcp_pkg::ACK_IDLE;
        ackhit = 1'b0;
    endtask

    function automatic logic [7:0] code_lookup();
        logic [31:0] f4;
        if (plen < 4)
            return rcp_pkg::CODE_NONE;
        f4 = (plen == 5) ? pfx[39:8] : pfx[31:0];
        case (f4)
            rcp_pkg::CODE_S256: return 8'd0;
            rcp_pkg::CODE_R64K: return 8'd1;
            rcp_pkg::CODE_R04K: return 8'd2;
            rcp_pkg::CODE_R256: return 8'd3;
            default:            return rcp_pkg::CODE_NONE;
        endcase
    endfunction

    task close_token();
        logic [31:0] v;
        logic [15:0] nar;
        v   = acc;
        nar = sens ? {8'h00, v[7:0]} : v[15:0];
        case (fld)
            3'd1: stamp = v;
            3'd2:
            begin
                if (plen == 5 && pfx == rcp_pkg::PREFIX_SENSOR)
                    sens = 1'b1;
                else
                    ms = v[15:0];
            end
            3'd3: kt = sens ? v[15:0] : {8'h00, code_lookup()};
            3'd4: idn = nar;
            3'd5: pay = nar;
            3'd6: snr = v[7:0];
            default: ;
        endcase
        if (fld < 3'd7)
            fld = fld + 3'd1;
        tok = 1'b0;
    endtask

    task scan_char(input logic [7:0] c);
        logic [31:0] d;
        if (c == rcp_pkg::CHAR_A)
            ackst = rcp_pkg::ACK_GOTA;
        else if (ackst == rcp_pkg::ACK_GOTA && c == rcp_pkg::CHAR_C)
            ackst = rcp_pkg::ACK_GOTC;
        else if (ackst == rcp_pkg::ACK_GOTC && c == rcp_pkg::CHAR_K)
        begin
            ackhit = 1'b1;
            ackst  = rcp_pkg::ACK_IDLE;
        end
        else
            ackst = rcp_pkg::ACK_IDLE;

        if (c == rcp_pkg::CHAR_COMMA)
        begin
            if (tok)
                close_token();
        end
        else
        begin
            if (!tok)
            begin
                tok  = 1'b1;
                acc  = 32'd0;
                pfx  = 40'd0;
                plen = 0;
                live = 1'b1;
            end
            if (plen < 5)
            begin
                pfx  = {pfx[31:0], c};
                plen = plen + 1;
            end
            if (live)
            begin
                if (c >= rcp_pkg::CHAR_ZERO && c <= rcp_pkg::CHAR_NINE)
                begin
                    d = {24'h0, c - rcp_pkg::CHAR_ZERO};
                    if (acc > (32'hFFFF_FFFF - d) / 32'd10)
                        acc = 32'hFFFF_FFFF;
                    else
                        acc = acc * 32'd10 + d;
                end
                else
                    live = 1'b0;
            end
        end
    endtask

    task pack_record();
        logic [7:0] bv [rcp_pkg::REC_BYTES];
        rec_word_t  w;
        int         k;
        bv[0] = stamp[31:24];
        bv[1] = stamp[23:16];
        bv[2] = stamp[15:8];
        bv[3] = stamp[7:0];
        if (!sens)
        begin
            bv[4]   = kt[7:0];
            bv[5]   = idn[15:8];
            bv[6]   = idn[7:0];
            bv[7]   = pay[15:8];
            bv[8]   = pay[7:0];
            bv[9]   = {snr[5:0], 2'b00} | ms[15:8];
            bv[10]  = ms[7:0];
            det_cnt = det_cnt + 32'd1;
        end
        else
        begin
            bv[4]   = FILL_BYTE;
            bv[5]   = kt[15:8];
            bv[6]   = kt[7:0];
            bv[7]   = idn[7:0];
            bv[8]   = pay[7:0];
            bv[9]   = FILL_BYTE;
            bv[10]  = snr;
            sen_cnt = sen_cnt + 32'd1;
        end
        for (k = 0; k < rcp_pkg::REC_BYTES; k++)
        begin
            w.data = bv[k];
            w.last = (k == rcp_pkg::REC_BYTES - 1);
            w.sens = sens;
            w.det  = det_cnt;
            w.sen  = sen_cnt;
            fresh_words.push_back(w);
        end
    endtask

    task parse_char(input logic [7:0] c);
        if (c != rcp_pkg::CHAR_NL)
        begin
            if (llen < LINE_CHARS)
            begin
                llen = llen + 1;
                scan_char(c);
            end
        end
        else
        begin
            if (tok)
                close_token();
            if (!ackhit && llen > rcp_pkg::MIN_LINE)
                pack_record();
            clear_line_state();
        end
    endtask

    task take_word(input logic [7:0] c, input int row);
        rec_word_t w;
        int        k;
        parse_char(c);
        if (row >= 0 && c == rcp_pkg::CHAR_NL && dir_rows[row].kind != ROW_PRED)
        begin
            if (dir_rows[row].kind == ROW_REC)
            begin
                for (k = 0; k < rcp_pkg::REC_BYTES; k++)
                begin
                    w.data = dir_rows[row].bytes[87 - 8 * k -: 8];
                    w.last = (k == rcp_pkg::REC_BYTES - 1);
                    w.sens = dir_rows[row].sens;
                    w.det  = dir_rows[row].det;
                    w.sen  = dir_rows[row].sen;
                    rec_exp_q.push_back(w);
                end
            end
        end
        else
        begin
            for (k = 0; k < fresh_words.size(); k++)
                rec_exp_q.push_back(fresh_words[k]);
        end
        fresh_words.delete();
    endtask

    task note_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task put_digits(input int n);
        repeat (n) line_buf.push_back(8'(rcp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    task put_sep();
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(2, 4)) line_buf.push_back(rcp_pkg::CHAR_COMMA);
        else
            line_buf.push_back(rcp_pkg::CHAR_COMMA);
    endtask

    task put_code();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 4:    put_str("S256");
            1, 5:    put_str("R64K");
            2, 6:    put_str("R04K");
            3, 7:    put_str("R256");
            8:       repeat ($urandom_range(4, 6))
                         line_buf.push_back(8'($urandom_range(8'h30, 8'h5A)));
            default: repeat ($urandom_range(1, 3))
                         line_buf.push_back(8'($urandom_range(8'h30, 8'h5A)));
        endcase
    endtask

    task put_field_num();
        if ($urandom_range(0, 9) == 0)
            put_str($urandom_range(0, 1) ? "-" : " ");
        put_digits(($urandom_range(0, 5) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 5));
    endtask

    task gen_line();
        int  kind;
        int  n;
        int  cut;
        bit  sensor_line;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) line_buf.push_back(rcp_pkg::CHAR_COMMA);
            cut         = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 6) : 7;
            sensor_line = ($urandom_range(0, 2) == 0);
            for (n = 0; n < cut; n++)
            begin
                if (n > 0)
                    put_sep();
                case (n)
                    0: put_digits($urandom_range(1, 3));
                    1: put_digits(($urandom_range(0, 4) == 0) ? $urandom_range(9, 12)
                                                              : $urandom_range(1, 8));
                    2:
                    begin
                        if (sensor_line)
                            put_str("TBR Sensor");
                        else
                            put_digits($urandom_range(1, 5));
                    end
                    3:
                    begin
                        if (sensor_line)
                            put_digits($urandom_range(1, 5));
                        else
                            put_code();
                    end
                    default: put_field_num();
                endcase
            end
            if ($urandom_range(0, 4) == 0)
            begin
                put_sep();
                put_str("ack");
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45) : $urandom_range(0, 24);
            if (n > 0)
                put_sep();
            repeat (n) line_buf.push_back(8'($urandom_range(8'h62, 8'h7A)));
        end
        else if (kind < 85)
            repeat ($urandom_range(0, 60)) line_buf.push_back(8'($urandom_range(0, 255)));
        else
            repeat ($urandom_range(0, 29))
                line_buf.push_back(($urandom_range(0, 3) == 0) ? rcp_pkg::CHAR_COMMA
                                   : 8'(rcp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        line_buf.push_back(rcp_pkg::CHAR_NL);
    endtask

    task wait_drained();
        while (feed_q.size() != 0 || ch_valid || rec_exp_q.size() != 0)
            @(negedge clk);
    endtask

    initial clear_line_state();

    // sender: hold the word until taken, then offer the next one
    always @(posedge clk)
    begin : send_side
        char_item_t item;
        if (!rst_n)
            ch_valid <= 1'b0;
        else
        begin
            if (ch_valid && ch_ready)
            begin
                take_word(ch, cur_row);
                chars_taken++;
            end
            if (!ch_valid || ch_ready)
            begin
                if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item = feed_q.pop_front();
                    ch       <= item.c;
                    cur_row  <= item.row;
                    ch_valid <= 1'b1;
                end
                else
                    ch_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : recv_side
        if (!rst_n)
            rec_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rec_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rec_ready <= 1'b0;
        end
        else
            rec_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_side
        rec_word_t w;
        if (rst_n && rec_valid && rec_ready)
        begin
            if (rec_exp_q.size() == 0)
                note_mismatch("word with nothing pending", {24'h0, out_byte}, 32'h0);
            else
            begin
                w = rec_exp_q.pop_front();
                if (out_byte !== w.data)
                    note_mismatch("out_byte", {24'h0, out_byte}, {24'h0, w.data});
                if (last_byte !== w.last)
                    note_mismatch("last_byte", {31'h0, last_byte}, {31'h0, w.last});
                if (is_sensor_record !== w.sens)
                    note_mismatch("is_sensor_record", {31'h0, is_sensor_record},
                                  {31'h0, w.sens});
                if (detections_total !== w.det)
                    note_mismatch("detections_total", detections_total, w.det);
                if (sensor_total !== w.sen)
                    note_mismatch("sensor_total", sensor_total, w.sen);
            end
            words_checked++;
            if (last_byte === 1'b1)
            begin
                records_seen++;
                if (is_sensor_record === 1'b1)
                    sensor_records++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n)
            idle_run <= 0;
        else if ((ch_valid && ch_ready) || (rec_valid && rec_ready))
            idle_run <= 0;
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin : main
        char_item_t item;
        int         r;
        int         i;
        int         phase;
        int         phase_chars;
        int         phase_lines;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stall the receiver once, as the table starts to stream in
        hold_req <= 1'b1;
        for (r = 0; r < DIR_ROWS; r++)
        begin
            for (i = 0; i < dir_rows[r].text.len(); i++)
            begin
                item.c   = dir_rows[r].text[i];
                item.row = r;
                if (item.c == NUL_MARK)
                    item.c = 8'h00;
                feed_q.push_back(item);
            end
            item.c   = rcp_pkg::CHAR_NL;
            item.row = r;
            feed_q.push_back(item);
            lines_sent++;
        end
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 18;
                    recv_idle_pct <= 76;
                end
                1:
                begin
                    send_idle_pct <= 76;
                    recv_idle_pct <= 18;
                end
                default:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            phase_chars = 0;
            phase_lines = 0;
            while (phase_chars < 60 || phase_lines < 2)
            begin
                gen_line();
                for (i = 0; i < line_buf.size(); i++)
                begin
                    item.c   = line_buf[i];
                    item.row = -1;
                    feed_q.push_back(item);
                end
                phase_chars += line_buf.size();
                phase_lines++;
                lines_sent++;
            end
            wait_drained();
        end

        repeat (8) @(negedge clk);

        $display("Sent %0d characters in %0d lines: edge lines under a long stall, then %s",
                 chars_taken, lines_sent, "random lines in three idling mixes.");
        $display("Checked %0d record words: %0d records, %0d of them sensor records.",
                 words_checked, records_seen, sensor_records);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
